// ===== rtl/rsi_pkg.sv =====
// Shared widths and types for the ray against segment intersection unit.
package rsi_pkg;

   localparam int COORD_BITS  = 24;
   localparam int DIR_BITS    = 16;
   localparam int T_FRAC_BITS = 24;

   // difference of two coordinates
   localparam int DIFF_W = COORD_BITS + 1;
   // difference times a direction component
   localparam int PROD_W = DIFF_W + DIR_BITS;
   // denominator and t numerator
   localparam int DEN_W  = PROD_W + 1;
   // cross product of two differences
   localparam int UPR_W  = 2 * DIFF_W;
   localparam int UCR_W  = UPR_W + 1;
   // lerp product
   localparam int LRP_W  = T_FRAC_BITS + DIFF_W;

   // payload carried alongside the divider
   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic        [DIFF_W-1:0]     mag_x;
      logic        [DIFF_W-1:0]     mag_y;
      logic                         neg_x;
      logic                         neg_y;
   } carry_type;

endpackage

// ===== rtl/rsi_if.sv =====
// Valid/ready channel interfaces for the request and response words.
interface rsi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rsi_pkg::COORD_BITS-1:0] seg_start_x;
   logic signed [rsi_pkg::COORD_BITS-1:0] seg_start_y;
   logic signed [rsi_pkg::COORD_BITS-1:0] seg_end_x;
   logic signed [rsi_pkg::COORD_BITS-1:0] seg_end_y;
   logic signed [rsi_pkg::COORD_BITS-1:0] ray_origin_x;
   logic signed [rsi_pkg::COORD_BITS-1:0] ray_origin_y;
   logic signed [rsi_pkg::DIR_BITS-1:0]   ray_dir_x;
   logic signed [rsi_pkg::DIR_BITS-1:0]   ray_dir_y;

   modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y, input ready);
   modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                   ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y, output ready);
endinterface

interface rsi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  hit;
   logic signed [rsi_pkg::COORD_BITS-1:0] hit_x;
   logic signed [rsi_pkg::COORD_BITS-1:0] hit_y;

   modport source (output valid, hit, hit_x, hit_y, input ready);
   modport sink   (input valid, hit, hit_x, hit_y, output ready);
endinterface

// ===== rtl/ray_segment_intersection_unit.sv =====
// Top level of the ray against wall segment intersection unit.
//
// Usage: one request word carries a wall segment (start and end point, signed
// Q16.8) and a ray (origin Q16.8, direction Q2.14). One response word follows
// for every request: hit, and the intersection point in Q16.8, or zeros when
// the ray misses the open segment interior or meets it at or behind its origin.
// Both channels are valid/ready; a word moves when valid and ready are high.
//
// Pipeline: differences, products, cross products, hit decision, one stage per
// quotient bit of the restoring divider (T_FRAC_BITS stages), the lerp
// multiply, and the output register. A new word enters every cycle while the
// output register is empty or drains; the per-bit divider stages set the
// depth, the quotient-bit subtract the clock.
//
// Stall: when the response is held and not taken, the whole pipe freezes and
// req_port.ready drops; nothing is lost or repeated. Bubbles ahead of the
// output move on only when the pipe advances.
//
// Reset clears the valid bits of every stage; payload registers keep junk.
module ray_segment_intersection_unit (
   input  logic        clock,
   input  logic        reset,
   rsi_req_if.sink     req_port,
   rsi_rsp_if.source   rsp_port
);

   localparam int C  = rsi_pkg::COORD_BITS;
   localparam int D  = rsi_pkg::DIR_BITS;
   localparam int T  = rsi_pkg::T_FRAC_BITS;
   localparam int DW = rsi_pkg::DIFF_W;
   localparam int PW = rsi_pkg::PROD_W;
   localparam int NW = rsi_pkg::DEN_W;
   localparam int UP = rsi_pkg::UPR_W;
   localparam int UW = rsi_pkg::UCR_W;
   localparam int LW = rsi_pkg::LRP_W;

   logic advance;
   logic out_valid_ff;

   // advance whenever the output register is free or being emptied
   assign advance        = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;

   // ---- stage 1: coordinate differences
   logic                 v1_ff;
   logic signed [DW-1:0] a_ff, b_ff, c_ff, e_ff;   // y1-y2, x1-x2, y1-y3, x1-x3
   logic signed [D-1:0]  dx_ff, dy_ff;
   logic signed [C-1:0]  x1_1_ff, y1_1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_port.valid;
      if (advance) begin
         a_ff    <= DW'(req_port.seg_start_y) - DW'(req_port.seg_end_y);
         b_ff    <= DW'(req_port.seg_start_x) - DW'(req_port.seg_end_x);
         c_ff    <= DW'(req_port.seg_start_y) - DW'(req_port.ray_origin_y);
         e_ff    <= DW'(req_port.seg_start_x) - DW'(req_port.ray_origin_x);
         dx_ff   <= req_port.ray_dir_x;
         dy_ff   <= req_port.ray_dir_y;
         x1_1_ff <= req_port.seg_start_x;
         y1_1_ff <= req_port.seg_start_y;
      end
   end

   // ---- stage 2: products
   logic                 v2_ff;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [UP-1:0] p5_ff, p6_ff;
   logic signed [DW-1:0] a2_ff, b2_ff;
   logic signed [C-1:0]  x1_2_ff, y1_2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         p1_ff   <= PW'(a_ff) * PW'(dx_ff);
         p2_ff   <= PW'(b_ff) * PW'(dy_ff);
         p3_ff   <= PW'(c_ff) * PW'(dx_ff);
         p4_ff   <= PW'(e_ff) * PW'(dy_ff);
         p5_ff   <= UP'(a_ff) * UP'(e_ff);
         p6_ff   <= UP'(b_ff) * UP'(c_ff);
         a2_ff   <= a_ff;
         b2_ff   <= b_ff;
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
      end
   end

   // ---- stage 3: cross products
   logic                 v3_ff;
   logic signed [NW-1:0] den_ff, tnum_ff;
   logic signed [UW-1:0] ucr_ff;
   logic signed [DW-1:0] a3_ff, b3_ff;
   logic signed [C-1:0]  x1_3_ff, y1_3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         den_ff  <= NW'(p1_ff) - NW'(p2_ff);
         tnum_ff <= NW'(p3_ff) - NW'(p4_ff);
         ucr_ff  <= UW'(p5_ff) - UW'(p6_ff);
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         x1_3_ff <= x1_2_ff;
         y1_3_ff <= y1_2_ff;
      end
   end

   // ---- stage 4: hit decision and divider operands
   logic [NW-1:0] n_mag, d_mag;
   logic          hit_in;

   always_comb begin
      n_mag  = tnum_ff[NW-1] ? NW'(-tnum_ff) : NW'(tnum_ff);
      d_mag  = den_ff[NW-1]  ? NW'(-den_ff)  : NW'(den_ff);
      // nonzero denominator, 0 < t < 1, u > 0
      hit_in = (den_ff != '0) && (tnum_ff != '0) && (tnum_ff[NW-1] == den_ff[NW-1])
               && (n_mag < d_mag) && (ucr_ff != '0) && (ucr_ff[UW-1] == den_ff[NW-1]);
   end

   logic                  dv_ff [0:T];
   logic [NW-1:0]         r_ff  [0:T];
   logic [NW-1:0]         dd_ff [0:T];
   logic [T-1:0]          q_ff  [0:T];
   rsi_pkg::carry_type    cy_ff [0:T];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (advance) dv_ff[0] <= v3_ff;
      if (advance) begin
         r_ff[0]        <= n_mag;
         dd_ff[0]       <= d_mag;
         q_ff[0]        <= '0;
         cy_ff[0].hit   <= hit_in;
         cy_ff[0].x1    <= x1_3_ff;
         cy_ff[0].y1    <= y1_3_ff;
         // segment runs toward lower x when x1 - x2 is positive
         cy_ff[0].neg_x <= !b3_ff[DW-1] && (b3_ff != '0);
         cy_ff[0].neg_y <= !a3_ff[DW-1] && (a3_ff != '0);
         cy_ff[0].mag_x <= b3_ff[DW-1] ? DW'(-b3_ff) : DW'(b3_ff);
         cy_ff[0].mag_y <= a3_ff[DW-1] ? DW'(-a3_ff) : DW'(a3_ff);
      end
   end

   // ---- divider: one restoring step per stage
   for (genvar i = 0; i < T; i++) begin : g_div
      logic [NW:0] shifted;
      logic [NW:0] trial;
      always_comb begin
         shifted = {r_ff[i], 1'b0};
         trial   = shifted - {1'b0, dd_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[i+1] <= 1'b0;
         else if (advance) dv_ff[i+1] <= dv_ff[i];
         if (advance) begin
            if (!trial[NW]) begin
               r_ff[i+1] <= trial[NW-1:0];
               q_ff[i+1] <= {q_ff[i][T-2:0], 1'b1};
            end else begin
               r_ff[i+1] <= shifted[NW-1:0];
               q_ff[i+1] <= {q_ff[i][T-2:0], 1'b0};
            end
            dd_ff[i+1] <= dd_ff[i];
            cy_ff[i+1] <= cy_ff[i];
         end
      end
   end

   // ---- lerp multiply
   logic               lv_ff;
   logic [LW-1:0]      lx_ff, ly_ff;
   rsi_pkg::carry_type lc_ff;

   always_ff @(posedge clock) begin
      if (reset) lv_ff <= 1'b0;
      else if (advance) lv_ff <= dv_ff[T];
      if (advance) begin
         lx_ff <= LW'(q_ff[T]) * LW'(cy_ff[T].mag_x);
         ly_ff <= LW'(q_ff[T]) * LW'(cy_ff[T].mag_y);
         lc_ff <= cy_ff[T];
      end
   end

   // ---- output register: step from the start point, zero on a miss
   logic [DW-1:0] stp_x, stp_y, px_in, py_in;

   always_comb begin
      stp_x = lx_ff[LW-1:T];
      stp_y = ly_ff[LW-1:T];
      px_in = lc_ff.neg_x ? DW'(lc_ff.x1) - stp_x : DW'(lc_ff.x1) + stp_x;
      py_in = lc_ff.neg_y ? DW'(lc_ff.y1) - stp_y : DW'(lc_ff.y1) + stp_y;
   end

   logic         hit_ff;
   logic [C-1:0] hx_ff, hy_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= lv_ff;
      if (advance) begin
         hit_ff <= lc_ff.hit;
         hx_ff  <= lc_ff.hit ? px_in[C-1:0] : '0;
         hy_ff  <= lc_ff.hit ? py_in[C-1:0] : '0;
      end
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.hit   = hit_ff;
   assign rsp_port.hit_x = hx_ff;
   assign rsp_port.hit_y = hy_ff;

endmodule
